>>> hdl/pidf_pkg.sv
`default_nettype none

package pidf_pkg;

   localparam int DATA_W = 32;
   localparam int DIFF_W = DATA_W + 1;          // derivative term, x - y
   localparam int PROD_W = DATA_W + DIFF_W;     // 32 x 33 signed product
   localparam int ACC_W  = 68;                  // sum of three products plus headroom
   localparam int FRAC_W = 16;                  // Q16.16
   localparam int STEP_W = 4;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);
   localparam logic signed [DATA_W-1:0] DERIV_SCALE = DATA_W'(100);

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_KP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FF = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FB = 3'd4;

   // microcode step addresses
   localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_MUL_KI = 4'd1;
   localparam logic [STEP_W-1:0] STEP_LD_KI  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_INTEG  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_LD_FF  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_ADD_FF = 4'd5;
   localparam logic [STEP_W-1:0] STEP_SUB_FB = 4'd6;
   localparam logic [STEP_W-1:0] STEP_FILT   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_MUL_KD = 4'd8;
   localparam logic [STEP_W-1:0] STEP_ADD_KD = 4'd9;
   localparam logic [STEP_W-1:0] STEP_DRIVE  = 4'd10;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_WAIT_REQ,
      JMP_WAIT_RSP
   } jump_type;

   typedef enum logic [2:0] {
      COEF_KP,
      COEF_KI,
      COEF_KD,
      COEF_FF,
      COEF_FB,
      COEF_SCALE
   } coef_sel_type;

   typedef enum logic [2:0] {
      DATA_ERR,
      DATA_X,
      DATA_XPREV,
      DATA_YPREV,
      DATA_DERIV
   } data_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB,
      ACC_LOAD_INT
   } acc_op_type;

   typedef struct packed {
      logic [STEP_W-1:0] next_step;
      jump_type          jump;
      coef_sel_type      coef_sel;
      data_sel_type      data_sel;
      acc_op_type        acc_op;
      logic              wb_integ;   // integrator and x from this step
      logic              wb_filt;    // filter output, taps, derivative
      logic              wb_drive;   // result into output register
   } uword_type;

   // Control store. The multiplier result is registered, so each acc_op
   // consumes the product whose operands were selected in the step before.
   function automatic uword_type ucode_rom(input logic [STEP_W-1:0] step);
      uword_type w;
      w           = '0;
      w.next_step = step + 4'd1;
      w.jump      = JMP_NEXT;
      w.coef_sel  = COEF_KP;
      w.data_sel  = DATA_ERR;
      w.acc_op    = ACC_HOLD;
      unique case (step)
         STEP_IDLE: begin
            w.jump = JMP_WAIT_REQ;
         end
         STEP_MUL_KI: begin
            w.coef_sel = COEF_KI;
         end
         STEP_LD_KI: begin
            w.acc_op   = ACC_LOAD;
            w.coef_sel = COEF_SCALE;
         end
         STEP_INTEG: begin
            w.wb_integ = 1'b1;
            w.coef_sel = COEF_FF;
            w.data_sel = DATA_XPREV;
         end
         STEP_LD_FF: begin
            w.acc_op   = ACC_LOAD;
            w.coef_sel = COEF_FF;
            w.data_sel = DATA_X;
         end
         STEP_ADD_FF: begin
            w.acc_op   = ACC_ADD;
            w.coef_sel = COEF_FB;
            w.data_sel = DATA_YPREV;
         end
         STEP_SUB_FB: begin
            w.acc_op   = ACC_SUB;
            w.coef_sel = COEF_KP;
         end
         STEP_FILT: begin
            w.wb_filt = 1'b1;
            w.acc_op  = ACC_LOAD_INT;
         end
         STEP_MUL_KD: begin
            w.coef_sel = COEF_KD;
            w.data_sel = DATA_DERIV;
         end
         STEP_ADD_KD: begin
            w.acc_op = ACC_ADD;
         end
         STEP_DRIVE: begin
            w.wb_drive  = 1'b1;
            w.jump      = JMP_WAIT_RSP;
            w.next_step = STEP_IDLE;
         end
         default: begin
            w.next_step = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   // true when a wide signed value does not fit in DATA_W bits
   function automatic logic is_clip(input logic signed [ACC_W-1:0] v);
      return !((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1]));
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (!is_clip(v)) begin
         r = v[DATA_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/pidf_mac.sv
`default_nettype none

module pidf_mac
   import pidf_pkg::*;
(
   input  wire logic                      clock,
   input  wire acc_op_type                acc_op,
   input  wire logic signed [DATA_W-1:0]  coef,
   input  wire logic signed [DIFF_W-1:0]  data,
   input  wire logic signed [DATA_W-1:0]  offset,
   output logic signed [PROD_W-1:0]       prod,
   output logic signed [ACC_W-1:0]        acc
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  prod_ext, offset_ext;

   assign prod_in    = coef * data;
   assign prod_ext   = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign offset_ext = {{(ACC_W-DATA_W){offset[DATA_W-1]}}, offset};

   always_comb begin
      case (acc_op)
         ACC_LOAD:     acc_in = prod_ext;
         ACC_ADD:      acc_in = acc_ff + prod_ext;
         ACC_SUB:      acc_in = acc_ff - prod_ext;
         ACC_LOAD_INT: acc_in = prod_ext + (offset_ext <<< FRAC_W);
         default:      acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

`default_nettype wire

>>> hdl/pid_with_filtered_derivative_unit.sv
`default_nettype none

// PID controller with filtered derivative, signed Q16.16.
// req channel: one transaction carries reference and measured; the block
//   takes it only when idle (req_ready high in the idle step).
// rsp channel: one transaction per request with drive and saturated.
// csr port: csr_we writes csr_wdata into register csr_index
//   (0 kp, 1 ki*Ts, 2 kd, 3 filter feedforward, 4 filter feedback);
//   indexes 5..7 are dropped. Write only while idle.
// Sequencing: each request runs the whole microcode program, which drives
//   one shared 32x33 multiplier and accumulator; a new request is taken
//   only once the program is back in its idle step.
// Stall: the result sits in an output register; while it is not taken one
//   more request can still be taken and run up to the last step, where the
//   program parks until the held result goes, and further requests wait.
// Reset: configuration registers, integrator and filter taps go to zero,
//   the sequencer to its idle step, rsp_valid low.

module pid_with_filtered_derivative_unit
   import pidf_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic signed [DATA_W-1:0]    req_reference,
   input  wire logic signed [DATA_W-1:0]    req_measured,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [DATA_W-1:0]         rsp_drive,
   output logic                             rsp_saturated,
   input  wire logic                        csr_we,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [DATA_W-1:0]           csr_wdata
);

   // configuration registers
   logic signed [DATA_W-1:0] kp_ff, ki_ff, kd_ff, ff_coef_ff, fb_coef_ff;

   // sequencer
   logic [STEP_W-1:0] step_ff, step_in;
   uword_type         uw;
   logic              req_accept;
   logic              rsp_free;

   // datapath state
   logic signed [DATA_W-1:0] err_ff, x_ff, xprev_ff, yprev_ff, integ_ff;
   logic signed [DIFF_W-1:0] deriv_ff;
   logic                     clip_ff;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_drive_ff;
   logic                     rsp_sat_ff;

   // datapath wires
   logic signed [DATA_W-1:0] coef_mux;
   logic signed [DIFF_W-1:0] data_mux;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  rnd_sum, rnd;
   logic signed [ACC_W-1:0]  integ_sum, prod_ext, diff_ext;
   logic signed [DIFF_W-1:0] diff_in;
   logic signed [DATA_W-1:0] y_in, drive_in;

   // ---------------------------------------------------------------
   // CSR writes
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff      <= '0;
         ki_ff      <= '0;
         kd_ff      <= '0;
         ff_coef_ff <= '0;
         fb_coef_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KP:  kp_ff      <= csr_wdata;
            CSR_KI:  ki_ff      <= csr_wdata;
            CSR_KD:  kd_ff      <= csr_wdata;
            CSR_FF:  ff_coef_ff <= csr_wdata;
            CSR_FB:  fb_coef_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Microcode sequencer
   // ---------------------------------------------------------------
   assign uw         = ucode_rom(step_ff);
   assign req_ready  = (uw.jump == JMP_WAIT_REQ);
   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (uw.jump)
         JMP_WAIT_REQ: step_in = req_accept ? uw.next_step : step_ff;
         JMP_WAIT_RSP: step_in = rsp_free ? uw.next_step : step_ff;
         default:      step_in = uw.next_step;
      endcase
   end

   // ---------------------------------------------------------------
   // Operand selection and shared multiply-accumulate
   // ---------------------------------------------------------------
   always_comb begin
      case (uw.coef_sel)
         COEF_KI:    coef_mux = ki_ff;
         COEF_KD:    coef_mux = kd_ff;
         COEF_FF:    coef_mux = ff_coef_ff;
         COEF_FB:    coef_mux = fb_coef_ff;
         COEF_SCALE: coef_mux = DERIV_SCALE;
         default:    coef_mux = kp_ff;
      endcase
   end

   always_comb begin
      case (uw.data_sel)
         DATA_X:     data_mux = {x_ff[DATA_W-1], x_ff};
         DATA_XPREV: data_mux = {xprev_ff[DATA_W-1], xprev_ff};
         DATA_YPREV: data_mux = {yprev_ff[DATA_W-1], yprev_ff};
         DATA_DERIV: data_mux = deriv_ff;
         default:    data_mux = {err_ff[DATA_W-1], err_ff};
      endcase
   end

   pidf_mac u_mac (
      .clock  (clock),
      .acc_op (uw.acc_op),
      .coef   (coef_mux),
      .data   (data_mux),
      .offset (integ_ff),
      .prod   (prod),
      .acc    (acc)
   );

   // round half up to Q16.16, then clip where needed
   assign rnd_sum   = acc + ROUND_HALF;
   assign rnd       = rnd_sum >>> FRAC_W;
   assign integ_sum = rnd + {{(ACC_W-DATA_W){integ_ff[DATA_W-1]}}, integ_ff};
   assign prod_ext  = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
   assign diff_in   = {req_reference[DATA_W-1], req_reference}
                    - {req_measured[DATA_W-1], req_measured};
   assign diff_ext  = {{(ACC_W-DIFF_W){diff_in[DIFF_W-1]}}, diff_in};
   assign y_in      = sat_data(rnd);
   assign drive_in  = sat_data(rnd);

   // ---------------------------------------------------------------
   // State updates
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         integ_ff     <= '0;
         xprev_ff     <= '0;
         yprev_ff     <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;

         // error is formed straight off the request ports
         if (req_accept) begin
            err_ff  <= sat_data(diff_ext);
            clip_ff <= 1'b0;
         end

         // integrator update and scaled error (e*100 is in the product reg)
         if (uw.wb_integ) begin
            integ_ff <= sat_data(integ_sum);
            clip_ff  <= is_clip(integ_sum);
            x_ff     <= sat_data(prod_ext);
         end

         // filter output; taps shift, derivative kept at 33 bits
         if (uw.wb_filt) begin
            yprev_ff <= y_in;
            xprev_ff <= x_ff;
            deriv_ff <= {x_ff[DATA_W-1], x_ff} - {y_in[DATA_W-1], y_in};
         end

         // output register
         if (uw.wb_drive && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_drive_ff <= drive_in;
            rsp_sat_ff   <= clip_ff || is_clip(rnd);
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = rsp_drive_ff;
   assign rsp_saturated = rsp_sat_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> step_ff == STEP_MUL_KI)
      else $error("request taken but program did not start");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(step_ff) == STEP_DRIVE)
      else $error("result raised outside the final step");

   a_park: assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_DRIVE && rsp_valid && !rsp_ready |=> step_ff == STEP_DRIVE)
      else $error("program left final step while result was stalled");

   a_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_DRIVE)
      else $error("step counter outside program");

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import pidf_pkg::*;

   localparam int GAIN_COUNT = int'(CSR_FB) + 1;
   localparam int SAMPLES_PER_SET = 90;
   localparam int SETS_PER_MIX = 3;
   localparam int SETTLE_CYCLES = 12;
   localparam int REPORT_LIMIT = 100;

   localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(1 << FRAC_W);
   localparam int SPAN = 1 << 20;       // +/-16.0, normal operating range
   localparam int NEAR = 1 << 17;       // +/-2.0, plant tracking its setpoint

   // 96 bits hold every exact sum of Q32.32 products the controller forms
   typedef logic signed [95:0] wide_type;
   localparam wide_type WIDE_HALF = ROUND_HALF;
   localparam wide_type WIDE_MAX = Q_MAX;
   localparam wide_type WIDE_MIN = Q_MIN;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive;
      logic                     saturated;
   } pid_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_reference = '0;
   logic signed [DATA_W-1:0] req_measured = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_drive;
   logic                     rsp_saturated;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [DATA_W-1:0]        csr_wdata = '0;

   // controller shadow: gains, integrator and filter taps
   logic signed [DATA_W-1:0] gain_reg [GAIN_COUNT] = '{default: '0};
   logic signed [DATA_W-1:0] integ_state = '0;
   logic signed [DATA_W-1:0] tap_in = '0;
   logic signed [DATA_W-1:0] tap_out = '0;

   pid_result_type drive_expected [$];

   int unsigned send_idle_pct = 21;
   int unsigned recv_idle_pct = 49;
   int unsigned error_count = 0;
   int unsigned samples_sent = 0;
   int unsigned results_checked = 0;
   int unsigned clipped_seen = 0;
   int unsigned gain_sets = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   pid_with_filtered_derivative_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_reference (req_reference),
      .req_measured  (req_measured),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_drive     (rsp_drive),
      .rsp_saturated (rsp_saturated),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Controller prediction
   // ------------------------------------------------------------------

   function automatic bit out_of_range(input wide_type v);
      return (v > WIDE_MAX) || (v < WIDE_MIN);
   endfunction

   function automatic logic signed [DATA_W-1:0] clamp_q(input wide_type v);
      if (v > WIDE_MAX) begin
         return Q_MAX;
      end
      if (v < WIDE_MIN) begin
         return Q_MIN;
      end
      return v[DATA_W-1:0];
   endfunction

   // One control step. All sums are exact; each sum of products is rounded
   // half up (add half an LSB, arithmetic shift), then clamped to 32 bits.
   function automatic pid_result_type step_controller(
      input logic signed [DATA_W-1:0] setpoint,
      input logic signed [DATA_W-1:0] plant
   );
      wide_type sp, pv, err, x, y, xp, yp, ig, acc;
      wide_type kp, ki, kd, ff, fb, scale;
      pid_result_type res;
      sp = setpoint;
      pv = plant;
      kp = gain_reg[CSR_KP];
      ki = gain_reg[CSR_KI];
      kd = gain_reg[CSR_KD];
      ff = gain_reg[CSR_FF];
      fb = gain_reg[CSR_FB];
      scale = DERIV_SCALE;
      res.saturated = 1'b0;

      // error clips silently
      err = clamp_q(sp - pv);

      // integrator, clipping is flagged
      acc = integ_state;
      acc = acc + ((ki * err + WIDE_HALF) >>> FRAC_W);
      if (out_of_range(acc)) begin
         res.saturated = 1'b1;
      end
      integ_state = clamp_q(acc);

      // Tustin low-pass on the scaled error; neither clip is flagged
      x = clamp_q(err * scale);
      xp = tap_in;
      yp = tap_out;
      acc = ff * x + ff * xp - fb * yp;
      y = clamp_q((acc + WIDE_HALF) >>> FRAC_W);
      tap_in = x[DATA_W-1:0];
      tap_out = y[DATA_W-1:0];

      // derivative x - y stays 33 bits wide; integrator joins unscaled
      ig = integ_state;
      acc = ((kp * err + kd * (x - y) + WIDE_HALF) >>> FRAC_W) + ig;
      if (out_of_range(acc)) begin
         res.saturated = 1'b1;
      end
      res.drive = clamp_q(acc);
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Shared transaction tasks
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      if (error_count < REPORT_LIMIT) begin
         $display("ERROR: %s differs at result %0d: got %h, want %h", what,
                  results_checked, got, want);
      end
      error_count++;
   endtask

   // Send one sample. Valid stays up after acceptance so back-to-back
   // samples need no extra NBA; it drops only when the sender goes idle.
   task automatic send_sample(input logic signed [DATA_W-1:0] setpoint,
                              input logic signed [DATA_W-1:0] plant);
      // now and then hold off until every pending result is back
      if ($urandom_range(63) == 0) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (drive_expected.size() != 0);
      end
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_reference <= setpoint;
      req_measured <= plant;
      do @(posedge clock); while (req_ready !== 1'b1);
      drive_expected.push_back(step_controller(setpoint, plant));
      samples_sent++;
   endtask

   // Stop sending and let the block go idle before touching the CSRs.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (drive_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all five gains, starting at a random register. Optionally
   // follow with writes to the unused indexes, which must not land.
   task automatic program_gains(input logic signed [DATA_W-1:0] kp_val,
                                input logic signed [DATA_W-1:0] ki_val,
                                input logic signed [DATA_W-1:0] kd_val,
                                input logic signed [DATA_W-1:0] ff_val,
                                input logic signed [DATA_W-1:0] fb_val,
                                input bit stray);
      logic signed [DATA_W-1:0] plan [GAIN_COUNT];
      int unsigned first, slot;
      plan[CSR_KP] = kp_val;
      plan[CSR_KI] = ki_val;
      plan[CSR_KD] = kd_val;
      plan[CSR_FF] = ff_val;
      plan[CSR_FB] = fb_val;
      first = $urandom_range(GAIN_COUNT - 1);
      for (int k = 0; k < GAIN_COUNT; k++) begin
         slot = (first + k) % GAIN_COUNT;
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(slot);
         csr_wdata <= plan[slot];
         @(posedge clock);
         gain_reg[slot] = plan[slot];
      end
      if (stray) begin
         for (int k = int'(CSR_FB) + 1; k < (1 << CSR_IDX_W); k++) begin
            csr_we <= 1'b1;
            csr_index <= CSR_IDX_W'(k);
            csr_wdata <= $urandom;
            @(posedge clock);
         end
      end
      csr_we <= 1'b0;
      gain_sets++;
   endtask

   // Gain styles: 0 plausible loop tuning, 1 anything goes, 2 rails or 0.
   function automatic logic signed [DATA_W-1:0] pick_gain(input int unsigned style,
                                                          input int unsigned slot);
      logic signed [DATA_W-1:0] g;
      case (style)
         0: begin
            case (slot)
               CSR_KP:  g = $urandom_range(4 * Q_ONE);
               CSR_KI:  g = $urandom_range(Q_ONE / 16);
               CSR_KD:  g = $urandom_range(Q_ONE);
               CSR_FF:  g = $urandom_range(Q_ONE / 4);
               default: g = -$signed(DATA_W'($urandom_range(Q_ONE)));
            endcase
            if ($urandom_range(7) == 0) begin
               g = -g;
            end
         end
         1: begin
            case ($urandom_range(4))
               0:       g = '0;
               1:       g = Q_MAX;
               2:       g = Q_MIN;
               3:       g = DATA_W'($urandom_range(2 * NEAR)) - DATA_W'(NEAR);
               default: g = $urandom;
            endcase
         end
         default: begin
            case ($urandom_range(2))
               0:       g = Q_MAX;
               1:       g = Q_MIN;
               default: g = '0;
            endcase
         end
      endcase
      return g;
   endfunction

   // ------------------------------------------------------------------
   // Result side: random backpressure, every transaction checked in order
   // ------------------------------------------------------------------

   initial begin
      pid_result_type want;
      forever begin
         @(posedge clock);
         if (reset !== 1'b1 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (drive_expected.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_drive, '0);
            end else begin
               want = drive_expected.pop_front();
               if (rsp_drive !== want.drive) begin
                  report_mismatch("drive", rsp_drive, want.drive);
               end
               if (rsp_saturated !== want.saturated) begin
                  report_mismatch("saturated flag", DATA_W'(rsp_saturated),
                                  DATA_W'(want.saturated));
               end
               if (want.saturated) begin
                  clipped_seen++;
               end
            end
            results_checked++;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Straight out of reset every gain is zero, so drive must be zero.
   task automatic test_reset_state();
      send_sample('0, '0);
      send_sample(Q_MAX, Q_MIN);
      send_sample($urandom, $urandom);
   endtask

   // Each gain lands in its own register; unused indexes are dropped.
   task automatic test_register_map();
      logic signed [DATA_W-1:0] setpoint;
      drain_pipeline();
      program_gains(2 * Q_ONE, Q_ONE / 4, Q_ONE / 2, Q_ONE / 10, -(Q_ONE * 4 / 5), 1'b1);
      repeat (6) begin
         setpoint = DATA_W'($urandom_range(2 * SPAN)) - DATA_W'(SPAN);
         send_sample(setpoint, setpoint + DATA_W'($urandom_range(2 * NEAR)) - DATA_W'(NEAR));
      end
   endtask

   // Rails and near-zero values on both inputs under a sane tuning; the
   // first two overflow the error itself and then the scaled error.
   task automatic test_field_extremes();
      drain_pipeline();
      program_gains(Q_ONE, Q_ONE / 64, Q_ONE / 8, Q_ONE / 8, -(Q_ONE * 3 / 4), 1'b0);
      send_sample(Q_MAX, Q_MIN);
      send_sample(Q_MIN, Q_MAX);
      send_sample(Q_MAX, Q_MAX);
      send_sample(Q_MIN, Q_MIN);
      send_sample('0, '0);
      send_sample('0, 1);
      send_sample(1, '0);
      send_sample(Q_MAX, '0);
   endtask

   // Integrator clipping alone (drive just follows it), both directions;
   // then rail gains clipping drive and a filter pinned opposite to its
   // input, which stretches the derivative to its full 33 bits.
   task automatic test_saturation();
      drain_pipeline();
      program_gains('0, Q_MAX, '0, '0, '0, 1'b0);
      repeat (3) send_sample(Q_MAX, Q_MIN);
      repeat (4) send_sample(Q_MIN, Q_MAX);
      drain_pipeline();
      program_gains(Q_MAX, Q_MIN, Q_ONE, Q_MIN, Q_MAX, 1'b1);
      send_sample(Q_MAX, Q_MIN);
      send_sample(Q_MIN, Q_MAX);
      send_sample(1, '0);
   endtask

   // Random traffic under one idle mix; gains change between sets.
   // Half the samples model a plant near its setpoint; the rest are wide.
   task automatic test_random_traffic(input int unsigned send_pct,
                                      input int unsigned recv_pct);
      logic signed [DATA_W-1:0] setpoint, plant;
      logic signed [DATA_W-1:0] g [GAIN_COUNT];
      for (int b = 0; b < SETS_PER_MIX; b++) begin
         drain_pipeline();
         send_idle_pct = send_pct;
         recv_idle_pct = recv_pct;
         for (int s = 0; s < GAIN_COUNT; s++) begin
            g[s] = pick_gain(gain_sets % 3, s);
         end
         program_gains(g[CSR_KP], g[CSR_KI], g[CSR_KD], g[CSR_FF], g[CSR_FB],
                       $urandom_range(1));
         repeat (SAMPLES_PER_SET) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4: begin
                  setpoint = DATA_W'($urandom_range(2 * SPAN)) - DATA_W'(SPAN);
                  plant = setpoint + DATA_W'($urandom_range(2 * NEAR)) - DATA_W'(NEAR);
               end
               5, 6: begin
                  setpoint = $urandom;
                  plant = $urandom;
               end
               7: begin
                  setpoint = $urandom_range(1) ? Q_MAX : Q_MIN;
                  plant = ($urandom_range(2) == 0) ? Q_MAX :
                          ($urandom_range(1) ? Q_MIN : '0);
               end
               8: begin
                  setpoint = DATA_W'($urandom_range(8 * Q_ONE)) - 4 * Q_ONE;
                  plant = DATA_W'($urandom_range(8 * Q_ONE)) - 4 * Q_ONE;
               end
               default: begin
                  // one LSB apart, anywhere in range
                  setpoint = $urandom;
                  plant = $urandom_range(1) ? setpoint + 1 : setpoint - 1;
               end
            endcase
            send_sample(setpoint, plant);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_register_map();
      test_field_extremes();
      test_saturation();
      test_random_traffic(21, 49);
      test_random_traffic(49, 21);
      test_random_traffic(0, 0);

      drain_pipeline();
      $display("run covered %0d samples under %0d gain settings, %0d results checked",
               samples_sent, gain_sets, results_checked);
      $display("%0d results carried the clip flag; %0d checks failed",
               clipped_seen, error_count);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> files.f
hdl/pidf_pkg.sv
hdl/pidf_mac.sv
hdl/pid_with_filtered_derivative_unit.sv
verif/tb.sv
